>>> hw/rtl/whbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whbr_pkg: shared types for the whitened-noise bounded random generator
// Value width, register index codes and the leading-one helper.
// ----------------------------------------------------------------------------
package whbr_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 1;

    typedef logic [VALUE_W-1:0] value_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_RANGE_LOW  = 1'b0,
        REG_RANGE_HIGH = 1'b1
    } reg_index_t;

    // Keep only the most significant set bit of x (zero stays zero)
    function automatic value_t msb_only(value_t x);
        value_t s;
        s = x;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        return s & ~(s >> 1);
    endfunction

endpackage

>>> hw/rtl/whbr_noise_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whbr_noise_if: raw noise bit channel
// Valid/ready channel carrying one raw noise bit per transfer.
// ----------------------------------------------------------------------------
interface whbr_noise_if;
    logic valid;
    logic ready;
    logic noise_bit;

    modport source (output valid, output noise_bit, input ready);
    modport sink   (input valid, input noise_bit, output ready);
endinterface

>>> hw/rtl/whbr_value_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whbr_value_if: bounded random value channel
// Valid/ready channel carrying one signed random value per transfer.
// ----------------------------------------------------------------------------
interface whbr_value_if;
    import whbr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

>>> hw/rtl/whitened_noise_bounded_random.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whitened_noise_bounded_random: debiased noise to uniform bounded values
// Two von Neumann stages whiten raw noise bits; whitened bits fill a value
// MSB first with rejection against the span, and results land in an output
// register that decouples the two channels.
// ----------------------------------------------------------------------------
// The block takes one raw noise bit per clock while ready is high and produces
// a result in the register stage right behind it, so an accepted bit that
// completes a value shows up on the value channel in the next cycle; a new
// bit is taken every cycle as long as no range rebuild is under way and the
// output register is empty or being drained. About sixteen raw bits make one
// whitened bit on unbiased noise; a value needs one whitened bit per bit of
// span - 1 plus retries on rejection. Each write to range_low or range_high
// holds noise ready low while the span and range flag, then its top bit, are
// rebuilt in two register steps; a write abandons the value in progress.
// ----------------------------------------------------------------------------
module whitened_noise_bounded_random (
    input  logic                    clk,
    input  logic                    rst_n,
    whbr_noise_if.sink              noise,
    whbr_value_if.source            value,
    input  logic                    wr_en,
    input  whbr_pkg::reg_index_t    wr_index,
    input  whbr_pkg::value_t        wr_data
);
    import whbr_pkg::*;

    localparam value_t RESET_LOW  = value_t'(0);
    localparam value_t RESET_HIGH = value_t'(256);

    // Configuration and derived range state
    value_t     range_low_reg,  range_low_next;
    value_t     range_high_reg, range_high_next;
    value_t     span_reg;
    value_t     top_reg;
    logic       degen_reg;
    logic [1:0] settle_reg,     settle_next;

    // Whitening and fill state
    logic       s1_have_reg, s1_have_next;
    logic       s1_bit_reg,  s1_bit_next;
    logic       s2_have_reg, s2_have_next;
    logic       s2_bit_reg,  s2_bit_next;
    value_t     partial_reg, partial_next;
    value_t     bitpos_reg,  bitpos_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    value_t     out_value_reg, out_value_next;

    value_t     span_calc;
    value_t     bp;
    value_t     pv;
    value_t     bp_shift;
    value_t     sum;
    logic       fire;
    logic       whit;

    assign fire        = noise.valid && noise.ready;
    assign noise.ready = (settle_reg == 2'd0) && (!out_valid_reg || value.ready);
    assign value.valid = out_valid_reg;
    assign value.random_value = $signed(out_value_reg);

    assign span_calc = range_high_reg - range_low_reg;

    // Write configuration registers
    always_comb
    begin
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        settle_next     = (settle_reg != 2'd0) ? settle_reg - 2'd1 : 2'd0;
        if (wr_en)
        begin
            settle_next = 2'd2;
            unique case (wr_index)
                REG_RANGE_LOW:  range_low_next  = wr_data;
                REG_RANGE_HIGH: range_high_next = wr_data;
                default:        range_low_next  = range_low_reg;
            endcase
        end
    end

    // Whiten, fill and reject
    always_comb
    begin
        s1_have_next   = s1_have_reg;
        s1_bit_next    = s1_bit_reg;
        s2_have_next   = s2_have_reg;
        s2_bit_next    = s2_bit_reg;
        partial_next   = partial_reg;
        bitpos_next    = bitpos_reg;
        out_valid_next = out_valid_reg && !value.ready;
        out_value_next = out_value_reg;
        whit           = 1'b0;

        bp       = (bitpos_reg == '0) ? top_reg : bitpos_reg;
        pv       = noise.noise_bit ? (partial_reg | bp) : partial_reg;
        bp_shift = bp >> 1;
        sum      = pv + range_low_reg;

        if (fire)
        begin
            if (!s1_have_reg)
            begin
                s1_bit_next  = noise.noise_bit;
                s1_have_next = 1'b1;
            end
            else
            begin
                s1_have_next = 1'b0;
                if (s1_bit_reg != noise.noise_bit)
                begin
                    if (!s2_have_reg)
                    begin
                        s2_bit_next  = noise.noise_bit;
                        s2_have_next = 1'b1;
                    end
                    else
                    begin
                        s2_have_next = 1'b0;
                        whit         = (s2_bit_reg != noise.noise_bit);
                    end
                end
            end
        end

        if (whit)
        begin
            if (degen_reg)
            begin
                // Empty or single-value range: emit the lower bound
                out_valid_next = 1'b1;
                out_value_next = range_low_reg;
            end
            else if (pv >= span_reg)
            begin
                // Reject and restart at the top bit
                partial_next = '0;
                bitpos_next  = top_reg;
            end
            else if (bp_shift == '0)
            begin
                out_valid_next = 1'b1;
                out_value_next = sum;
                partial_next   = '0;
                bitpos_next    = '0;
            end
            else
            begin
                partial_next = pv;
                bitpos_next  = bp_shift;
            end
        end

        // Drop the value in progress on any register write
        if (wr_en)
        begin
            partial_next = '0;
            bitpos_next  = '0;
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= RESET_LOW;
            range_high_reg <= RESET_HIGH;
            span_reg       <= RESET_HIGH - RESET_LOW;
            top_reg        <= msb_only(RESET_HIGH - RESET_LOW - value_t'(1));
            degen_reg      <= 1'b0;
            settle_reg     <= 2'd0;
            s1_have_reg    <= 1'b0;
            s1_bit_reg     <= 1'b0;
            s2_have_reg    <= 1'b0;
            s2_bit_reg     <= 1'b0;
            partial_reg    <= '0;
            bitpos_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
            span_reg       <= span_calc;
            top_reg        <= msb_only(span_reg - value_t'(1));
            degen_reg      <= ($signed(range_low_reg) >= $signed(range_high_reg))
                              || (span_calc == value_t'(1));
            settle_reg     <= settle_next;
            s1_have_reg    <= s1_have_next;
            s1_bit_reg     <= s1_bit_next;
            s2_have_reg    <= s2_have_next;
            s2_bit_reg     <= s2_bit_next;
            partial_reg    <= partial_next;
            bitpos_reg     <= bitpos_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
    end

`ifndef NO_ASSERTIONS
    a_no_take_while_settling: assert property (@(posedge clk) disable iff (!rst_n)
        (settle_reg != 2'd0) |-> !noise.ready)
        else $error("noise taken while range state was rebuilding");

    a_bitpos_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(bitpos_reg))
        else $error("fill position is not a single bit");

    a_partial_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        (settle_reg == 2'd0 && !degen_reg) |-> (partial_reg < span_reg))
        else $error("partial value reached the span");

    a_stages_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable({s1_have_reg, s2_have_reg}))
        else $error("whitening state moved without a transfer");

    a_result_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire))
        else $error("result appeared without an accepted noise bit");
`endif

endmodule
